### hw/rtl/apr_pkg.sv
// Shared types and constants for the adaptive peak rate meter.
package apr_pkg;

	localparam int WINDOW_DEF = 20;
	localparam int VAL_W      = 48;
	localparam int RATE_W     = 40;
	localparam int FRAC_W     = 16;
	localparam int PEAK_W     = 56;
	localparam int NUM_W      = 68;
	localparam int LVL_W      = 17;
	localparam int DECAY_W    = 16;
	localparam int FLOOR_W    = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int QDEPTH     = 2;

	localparam logic [DECAY_W-1:0]   DECAY_RST    = 16'd65529;
	localparam logic [FLOOR_W-1:0]   FLOOR_RST    = 32'd4096;
	localparam logic [19:0]          USEC_PER_SEC = 20'd1000000;
	localparam logic [RATE_W-1:0]    RATE_MAX     = {RATE_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 8'd1;

	typedef struct packed {
		logic             go;
		logic [VAL_W-1:0] dr;
		logic [VAL_W-1:0] dw;
		logic [VAL_W-1:0] dt;
	} job_t;

	typedef struct packed {
		logic [DECAY_W-1:0] decay;
		logic [FLOOR_W-1:0] floor;
	} cfg_t;

endpackage

### hw/rtl/apr_ifs.sv
// Channel interfaces: sample input, level result, configuration write.
interface apr_smp_if;
	logic        valid;
	logic        ready;
	logic [47:0] read_total;
	logic [47:0] write_total;
	logic [47:0] time_usec;
	modport source (output valid, read_total, write_total, time_usec, input ready);
	modport sink (input valid, read_total, write_total, time_usec, output ready);
endinterface

interface apr_res_if;
	logic        valid;
	logic        ready;
	logic [16:0] read_level;
	logic [16:0] write_level;
	modport source (output valid, read_level, write_level, input ready);
	modport sink (input valid, read_level, write_level, output ready);
endinterface

interface apr_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/apr_front.sv
// Front end: takes samples, keeps the history ring, forms deltas against the oldest entry.
module apr_front #(
	parameter int WINDOW = apr_pkg::WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	apr_smp_if.sink       smp,
	output logic          push,
	output apr_pkg::job_t job,
	input  logic          q_ready
);
	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int EW = 3 * apr_pkg::VAL_W;

	typedef enum logic {F_IDLE, F_PUSH} fstate_t;

	fstate_t         state_q;
	logic [IW-1:0]   slot_q;
	logic [CW-1:0]   fill_q;
	logic            hist_q;
	logic [EW-1:0]   cur_q;
	logic [EW-1:0]   old_q;
	logic [EW-1:0]   mem [WINDOW];
	logic [EW-1:0]   new_ent;
	logic [CW:0]     old_w;
	logic [IW-1:0]   old_idx;
	logic            acc;
	logic [apr_pkg::VAL_W-1:0] dt;

	assign smp.ready = (state_q == F_IDLE);
	assign acc       = smp.valid && smp.ready;
	assign new_ent   = {smp.time_usec, smp.read_total, smp.write_total};

	// oldest held entry sits fill slots behind the write slot
	always_comb begin
		old_w = (CW+1)'(slot_q) - (CW+1)'(fill_q);
		if (old_w[CW]) begin
			old_w = old_w + (CW+1)'(WINDOW);
		end
		old_idx = old_w[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			old_q        <= mem[old_idx];
			mem[slot_q]  <= new_ent;
			cur_q        <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
			hist_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						hist_q  <= (fill_q != '0);
						slot_q  <= (slot_q == IW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
						if (fill_q != CW'(WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (q_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign dt      = cur_q[EW-1 -: 48] - old_q[EW-1 -: 48];
	assign push    = (state_q == F_PUSH);
	assign job.dt  = dt;
	assign job.dr  = cur_q[95:48] - old_q[95:48];
	assign job.dw  = cur_q[47:0] - old_q[47:0];
	assign job.go  = hist_q && (dt != '0);

endmodule

### hw/rtl/apr_queue.sv
// Small FIFO between the front end and the arithmetic back end.
module apr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  apr_pkg::job_t job_in,
	output logic          in_ready,
	output logic          out_valid,
	output apr_pkg::job_t job_out,
	input  logic          pop
);
	localparam int D  = apr_pkg::QDEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int NW = $clog2(D + 1);

	apr_pkg::job_t   ent_q [D];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [NW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign in_ready  = (cnt_q != NW'(D));
	assign out_valid = (cnt_q != '0);
	assign job_out   = ent_q[rp_q];
	assign do_push   = push && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/apr_back.sv
// Back end: peak decay, serial rate and level division for both channels.
module apr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  apr_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  apr_pkg::job_t job,
	output logic          q_pop,
	apr_res_if.source     res
);
	localparam int PW = apr_pkg::PEAK_W;
	localparam int RW = apr_pkg::RATE_W;
	localparam int NW = apr_pkg::NUM_W;
	localparam int VW = apr_pkg::VAL_W;
	localparam int LW = apr_pkg::LVL_W;
	localparam logic [PW-1:0] PEAK_RST = {8'd0, apr_pkg::FLOOR_RST, 16'd0};

	typedef enum logic [2:0] {
		B_IDLE, B_DECAY, B_FLOOR, B_CHK, B_RDIV, B_RAISE, B_LDIV, B_DONE
	} bstate_t;

	bstate_t         state_q;
	apr_pkg::job_t   job_q;
	logic [5:0]      cnt_q;
	logic [PW-1:0]   peak_q  [2];
	logic [PW-1:0]   prhi_q  [2];
	logic [31:0]     prlo_q  [2];
	logic [NW-1:0]   num_q   [2];
	logic            cap_q   [2];
	logic [VW:0]     rem_q   [2];
	logic [RW-1:0]   quo_q   [2];
	logic [RW-1:0]   rate_q  [2];
	logic [PW:0]     lrem_q  [2];
	logic [LW-1:0]   lquo_q  [2];
	logic            rvalid_q;
	logic [LW-1:0]   rl_q;
	logic [LW-1:0]   wl_q;

	logic [VW-1:0]   bytes   [2];
	logic [PW-1:0]   dec_v   [2];
	logic [PW-1:0]   fl_v;
	logic [VW:0]     rtry    [2];
	logic [RW-1:0]   rsel    [2];
	logic [PW-1:0]   r16     [2];
	logic [PW:0]     ltry    [2];
	logic            out_free;

	assign bytes[0] = job_q.dr;
	assign bytes[1] = job_q.dw;
	assign fl_v     = {8'd0, cfg.floor, 16'd0};
	assign q_pop    = (state_q == B_IDLE) && q_valid;
	assign out_free = !rvalid_q || res.ready;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			dec_v[c] = prhi_q[c] + PW'(prlo_q[c][31:16]);
			rtry[c]  = {rem_q[c][VW-1:0], num_q[c][RW-1]};
			rsel[c]  = cap_q[c] ? apr_pkg::RATE_MAX : quo_q[c];
			r16[c]   = {rsel[c], 16'd0};
			ltry[c]  = {lrem_q[c][PW-1:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					job_q <= job;
				end
			end
			B_DECAY: begin
				for (int c = 0; c < 2; c++) begin
					prhi_q[c] <= PW'(peak_q[c][PW-1:16]) * PW'(cfg.decay);
					prlo_q[c] <= peak_q[c][15:0] * cfg.decay;
					num_q[c]  <= NW'(bytes[c]) * NW'(apr_pkg::USEC_PER_SEC);
				end
			end
			B_FLOOR: begin
				for (int c = 0; c < 2; c++) begin
					rate_q[c] <= '0;
					lquo_q[c] <= '0;
				end
			end
			B_CHK: begin
				// quotient reaches 2^40 exactly when num >= dt << 40
				for (int c = 0; c < 2; c++) begin
					cap_q[c] <= ({20'd0, num_q[c]} >= {job_q.dt, 40'd0});
					rem_q[c] <= (VW+1)'(num_q[c][NW-1:RW]);
					quo_q[c] <= '0;
				end
				cnt_q <= '0;
			end
			B_RDIV: begin
				for (int c = 0; c < 2; c++) begin
					num_q[c] <= num_q[c] << 1;
					if (rtry[c] >= {1'b0, job_q.dt}) begin
						rem_q[c] <= rtry[c] - {1'b0, job_q.dt};
						quo_q[c] <= {quo_q[c][RW-2:0], 1'b1};
					end else begin
						rem_q[c] <= rtry[c];
						quo_q[c] <= {quo_q[c][RW-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end
			B_RAISE: begin
				// peak >= rate << 16 now, so the level fits 17 bits
				for (int c = 0; c < 2; c++) begin
					rate_q[c] <= rsel[c];
					lrem_q[c] <= {2'b00, rsel[c], 15'd0};
					lquo_q[c] <= '0;
				end
				cnt_q <= '0;
			end
			B_LDIV: begin
				for (int c = 0; c < 2; c++) begin
					if (ltry[c] >= {1'b0, peak_q[c]}) begin
						lrem_q[c] <= ltry[c] - {1'b0, peak_q[c]};
						lquo_q[c] <= {lquo_q[c][LW-2:0], 1'b1};
					end else begin
						lrem_q[c] <= ltry[c];
						lquo_q[c] <= {lquo_q[c][LW-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			peak_q[0] <= PEAK_RST;
			peak_q[1] <= PEAK_RST;
			rvalid_q  <= 1'b0;
			rl_q      <= '0;
			wl_q      <= '0;
		end else begin
			if (rvalid_q && res.ready && state_q != B_DONE) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_DECAY;
					end
				end
				B_DECAY: state_q <= B_FLOOR;
				B_FLOOR: begin
					for (int c = 0; c < 2; c++) begin
						peak_q[c] <= (dec_v[c] < fl_v) ? fl_v : dec_v[c];
					end
					state_q <= job_q.go ? B_CHK : B_DONE;
				end
				B_CHK: state_q <= B_RDIV;
				B_RDIV: begin
					if (cnt_q == 6'(RW - 1)) begin
						state_q <= B_RAISE;
					end
				end
				B_RAISE: begin
					for (int c = 0; c < 2; c++) begin
						if (r16[c] > peak_q[c]) begin
							peak_q[c] <= r16[c];
						end
					end
					state_q <= B_LDIV;
				end
				B_LDIV: begin
					if (cnt_q == 6'(LW - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						rvalid_q <= 1'b1;
						rl_q     <= (rate_q[0] == '0) ? '0 : lquo_q[0];
						wl_q     <= (rate_q[1] == '0) ? '0 : lquo_q[1];
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign res.valid       = rvalid_q;
	assign res.read_level  = rl_q;
	assign res.write_level = wl_q;

endmodule

### hw/rtl/adaptive_peak_rate_meter.sv
// Top level of the adaptive peak rate meter: config registers and front/back hookup.
//
// Usage:
//   smp: one transfer per sample (read_total, write_total, time_usec, all 48 bit).
//   res: one transfer per sample carrying read_level and write_level, Q0.16,
//        65536 is full scale; results come out in sample order.
//   cfg: index 0 writes decay_factor (Q0.16), index 1 writes rate_floor
//        (bytes/s); other indexes are dropped. Always ready; write only when idle.
// Flow:
//   The front end takes a sample through ring read, delta and queue push and
//   accepts no new one until the queue takes the push. The back end works a
//   sample through decay multiply and floor, a 40-step restoring divide for the
//   rate and a 17-step divide for the level, both channels side by side, and
//   takes no new sample before its result is registered; that divider loop sets
//   throughput. With empty history or zero time delta both divides are skipped.
// Reset: history empty, peaks at 4096 bytes/s, registers at their defaults.
// A stalled receiver holds the result register; the back end stops at its
// last step and the two-entry queue then fills before smp stops accepting.
module adaptive_peak_rate_meter #(
	parameter int WINDOW = apr_pkg::WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	apr_smp_if.sink   smp,
	apr_res_if.source res,
	apr_cfg_if.sink   cfg
);
	apr_pkg::cfg_t  cfg_q;
	apr_pkg::job_t  fjob;
	apr_pkg::job_t  bjob;
	logic           fpush;
	logic           q_ready;
	logic           q_valid;
	logic           q_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay <= apr_pkg::DECAY_RST;
			cfg_q.floor <= apr_pkg::FLOOR_RST;
		end else if (cfg.valid) begin
			if (cfg.index == apr_pkg::REG_DECAY) begin
				cfg_q.decay <= cfg.data[apr_pkg::DECAY_W-1:0];
			end else if (cfg.index == apr_pkg::REG_FLOOR) begin
				cfg_q.floor <= cfg.data;
			end
		end
	end

	apr_front #(.WINDOW(WINDOW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (smp),
		.push    (fpush),
		.job     (fjob),
		.q_ready (q_ready)
	);

	apr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fpush),
		.job_in    (fjob),
		.in_ready  (q_ready),
		.out_valid (q_valid),
		.job_out   (bjob),
		.pop       (q_pop)
	);

	apr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.job     (bjob),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the adaptive peak rate meter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import apr_pkg::*;

	localparam int WIN = 20;
	localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [16:0] rd_lvl;
		logic [16:0] wr_lvl;
	} levels_t;

	typedef struct {
		logic [47:0] rd;
		logic [47:0] wr;
		logic [47:0] t;
		bit          typed;
		levels_t     lv;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	apr_smp_if smp ();
	apr_res_if res ();
	apr_cfg_if cfg ();

	adaptive_peak_rate_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the meter
	logic [47:0]        hist_t [WIN];
	logic [47:0]        hist_r [WIN];
	logic [47:0]        hist_w [WIN];
	int                 next_slot;
	int                 held;
	logic [55:0]        peak_rd;
	logic [55:0]        peak_wr;
	logic [DECAY_W-1:0] decay_q16;
	logic [FLOOR_W-1:0] floor_bps;

	levels_t level_q[$];
	int      errors = 0;
	bit      calm = 0;
	int      stall_left = 0;

	function automatic logic [55:0] decayed(logic [55:0] pk);
		logic [63:0] v;
		logic [63:0] fl;
		v  = 64'(pk[55:16]) * decay_q16 + ((64'(pk[15:0]) * decay_q16) >> 16);
		fl = 64'(floor_bps) << 16;
		return (v < fl) ? fl[55:0] : v[55:0];
	endfunction

	function automatic logic [39:0] bytes_per_sec(logic [47:0] bytes, logic [47:0] dt);
		logic [127:0] q;
		q = (128'(bytes) * 128'd1000000) / 128'(dt);
		return (q > 128'(RATE_MAX)) ? RATE_MAX : q[39:0];
	endfunction

	function automatic logic [16:0] level_of(logic [39:0] rate, ref logic [55:0] pk);
		logic [127:0] q;
		if ({rate, 16'b0} > pk)
			pk = {rate, 16'b0};
		if (rate == 0 || pk == 0)
			return 17'd0;
		q = {56'b0, rate, 32'b0} / 128'(pk);
		return (q > 128'd65536) ? 17'd65536 : q[16:0];
	endfunction

	function automatic levels_t meter_step(logic [47:0] rd, logic [47:0] wr, logic [47:0] t);
		levels_t     lv;
		int          old;
		logic [47:0] dt;
		lv = '0;
		peak_rd = decayed(peak_rd);
		peak_wr = decayed(peak_wr);
		if (held > 0) begin
			old = (next_slot + WIN - held) % WIN;
			dt = t - hist_t[old];
			if (dt != 0) begin
				lv.rd_lvl = level_of(bytes_per_sec(rd - hist_r[old], dt), peak_rd);
				lv.wr_lvl = level_of(bytes_per_sec(wr - hist_w[old], dt), peak_wr);
			end
		end
		hist_t[next_slot] = t;
		hist_r[next_slot] = rd;
		hist_w[next_slot] = wr;
		next_slot = (next_slot + 1) % WIN;
		if (held < WIN)
			held++;
		return lv;
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg.index <= idx;
		cfg.data  <= val;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_DECAY)
			decay_q16 = val[DECAY_W-1:0];
		else if (idx == REG_FLOOR)
			floor_bps = val;
	endtask

	task automatic send_sample(logic [47:0] rd, logic [47:0] wr, logic [47:0] t,
			bit typed, levels_t lv);
		levels_t pred;
		int      gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.read_total  <= rd;
		smp.write_total <= wr;
		smp.time_usec   <= t;
		smp.valid       <= 1'b1;
		do @(posedge clk); while (!smp.ready);
		pred = meter_step(rd, wr, t);
		level_q.push_back(typed ? lv : pred);
	endtask

	// Wait for all results, then let the back end settle before a register write
	task automatic drain();
		smp.valid <= 1'b0;
		while (level_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		levels_t want;
		if (arst_n && res.valid && res.ready) begin
			if (level_q.size() == 0) begin
				$error("unexpected result transfer: read_level %0d write_level %0d",
					res.read_level, res.write_level);
				errors++;
			end else begin
				want = level_q.pop_front();
				if (res.read_level !== want.rd_lvl) begin
					$error("read_level mismatch: expected %0d, got %0d",
						want.rd_lvl, res.read_level);
					errors++;
				end
				if (res.write_level !== want.wr_lvl) begin
					$error("write_level mismatch: expected %0d, got %0d",
						want.wr_lvl, res.write_level);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		sample_row_t table_rows[$];
		logic [47:0] cur_t, cur_r, cur_w, rd, wr, t;
		logic [31:0] phase_decay[5];
		logic [31:0] phase_floor[5];
		int          pick;

		smp.valid = 1'b0;
		smp.read_total = '0;
		smp.write_total = '0;
		smp.time_usec = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;

		next_slot = 0;
		held = 0;
		decay_q16 = DECAY_RST;
		floor_bps = FLOOR_RST;
		peak_rd = {8'b0, FLOOR_RST, 16'b0};
		peak_wr = {8'b0, FLOOR_RST, 16'b0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset configuration
		table_rows = '{
			'{48'd0, 48'd0, 48'd1000, 1, '{17'd0, 17'd0}},      // empty history
			'{48'd0, 48'd0, 48'd1000, 1, '{17'd0, 17'd0}},      // zero time delta
			'{48'd4096, 48'd100, 48'd1001000, 0, '0},
			'{48'd1000000, 48'd0, 48'd2001000, 0, '0},
			'{ALL48, ALL48, 48'd2001001, 0, '0},                 // rate saturates
			'{48'd5, 48'd7, 48'd0, 0, '0},                       // time backwards
			'{ALL48, 48'd0, ALL48, 0, '0},
			'{48'd0, ALL48, 48'd12, 0, '0},
			'{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 0, '0},
			'{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 0, '0},
			'{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAB, 0, '0},
			'{48'd1, 48'd1, 48'd1, 0, '0}
		};
		foreach (table_rows[i])
			send_sample(table_rows[i].rd, table_rows[i].wr, table_rows[i].t,
				table_rows[i].typed, table_rows[i].lv);

		phase_decay = '{32'd65529, 32'd65535, 32'd0, 32'd32768, 32'd65529};
		phase_floor = '{32'd4096, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0};

		cur_t = 48'd2000;
		cur_r = '0;
		cur_w = '0;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(REG_DECAY, phase_decay[ph]);
			write_reg(REG_FLOOR, phase_floor[ph]);
			// indexes past the register map must be dropped
			write_reg(8'd2 + 8'($urandom_range(0, 253)), $urandom);
			if (ph == 4)
				calm = 1;
			for (int n = 0; n < 328; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					// well-formed: time and totals step forward by random amounts, modulo 2^48
					case ($urandom_range(0, 3))
						0: cur_t += 48'($urandom_range(1, 100));
						1: cur_t += 48'($urandom_range(50000, 150000));
						2: cur_t += 48'($urandom_range(1, 2000000));
						default: cur_t += (pick < 3) ? 48'd0 : 48'($urandom_range(1, 10));
					endcase
					for (int ch = 0; ch < 2; ch++) begin
						logic [47:0] inc;
						case ($urandom_range(0, 4))
							0: inc = '0;
							1: inc = 48'($urandom_range(0, 4096));
							2: inc = 48'($urandom);
							3: inc = {8'($urandom), 32'($urandom)};
							default: inc = {16'($urandom), 32'($urandom)};
						endcase
						if (ch == 0)
							cur_r += inc;
						else
							cur_w += inc;
					end
					rd = cur_r;
					wr = cur_w;
					t = cur_t;
				end else begin
					// noise: arbitrary fields, time may jump anywhere
					rd = {16'($urandom), 32'($urandom)};
					wr = {16'($urandom), 32'($urandom)};
					t = {16'($urandom), 32'($urandom)};
					if (pick < 93) begin
						cur_t = t;
						cur_r = rd;
						cur_w = wr;
					end
				end
				send_sample(rd, wr, t, 0, '0);
			end
		end

		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
